// ===== rtl/chte_pkg.sv =====
// chte_pkg: shared types and constants for the chained hash table engine
// no dependencies; imported by every module of the block
package chte_pkg;

   // fixed field widths
   localparam int KEY_W        = 64;
   localparam int VAL_W        = 32;
   localparam int OP_W         = 2;
   localparam int TS_W         = 7;
   localparam int ENTRY_W      = 7;
   localparam int KEY_MAX      = 16;
   localparam int BUCKET_MAX_W = 12;
   localparam int SUM_MAX_W    = 12;

   // table size after reset
   localparam logic [TS_W-1:0] TS_RESET = 7'd64;

   // opcodes; every other code searches
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   // one classified transaction handed from front to back
   typedef struct packed {
      logic [OP_W-1:0]         op;
      logic [KEY_W-1:0]        key_low;
      logic [KEY_W-1:0]        key_high;
      logic signed [VAL_W-1:0] value;
      logic [BUCKET_MAX_W-1:0] bucket;
   } work_type;

   // back part status seen by the top level
   typedef struct packed {
      logic clearing;
      logic empty;
   } back_status_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_SUM,
      F_DIV,
      F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_CLEAR,
      B_IDLE,
      B_HEAD,
      B_NODE,
      B_DECIDE,
      B_POP,
      B_LINK,
      B_LINKP
   } back_state_type;

endpackage

// ===== rtl/chte_front.sv =====
// chte_front: accepts transactions, canonicalizes the key, sums its bytes and
// reduces the sum modulo the table size one bit per cycle; depends on chte_pkg
module chte_front import chte_pkg::*; #(
   parameter int BUCKETS   = 64,
   parameter int KEY_BYTES = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    hold,
   output logic                    front_busy,
   input  logic [OP_W-1:0]         req_opcode,
   input  logic [KEY_W-1:0]        req_key_low,
   input  logic [KEY_W-1:0]        req_key_high,
   input  logic signed [VAL_W-1:0] req_new_value,
   input  logic [TS_W-1:0]         table_size,
   output logic                    push,
   output work_type                push_data,
   input  logic                    queue_full
);

   localparam int SUM_W = $clog2(KEY_BYTES * 255 + 1);
   localparam int DV_W  = $clog2(BUCKETS + 1);
   localparam int BC_W  = $clog2(SUM_W + 1);

   front_state_type state_ff, state_in;
   logic [OP_W-1:0]         op_ff;
   logic [KEY_W-1:0]        klo_ff, khi_ff, klo_in, khi_in;
   logic signed [VAL_W-1:0] val_ff;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [DV_W-1:0]         div_ff, div_in;
   logic [DV_W-1:0]         rem_ff, rem_in;
   logic [BC_W-1:0]         bit_ff, bit_in;
   logic                    accept;
   logic [DV_W:0]           shifted;
   logic [2*KEY_W-1:0]      key_all;
   logic [SUM_MAX_W-1:0]    lvl1 [8];
   logic [SUM_MAX_W-1:0]    lvl2 [4];
   logic [SUM_MAX_W-1:0]    lvl3 [2];
   logic [SUM_MAX_W-1:0]    total;

   assign accept     = start && !hold && (state_ff == F_IDLE);
   assign front_busy = (state_ff != F_IDLE);

   // canonical key: keep bytes up to the first zero byte and below the key length
   always_comb begin
      logic       alive;
      logic [7:0] b;
      alive  = 1'b1;
      klo_in = '0;
      khi_in = '0;
      for (int i = 0; i < KEY_MAX; i++) begin
         b     = (i < 8) ? req_key_low[8*i +: 8] : req_key_high[8*(i-8) +: 8];
         alive = alive && (b != 8'd0) && (i < KEY_BYTES);
         if (alive) begin
            if (i < 8) klo_in[8*i +: 8] = b;
            else       khi_in[8*(i-8) +: 8] = b;
         end
      end
   end

   // effective divisor: zero counts as one, clamp to the bucket count
   always_comb begin
      if (table_size == '0) begin
         div_in = DV_W'(1);
      end else if (32'(table_size) > BUCKETS) begin
         div_in = DV_W'(BUCKETS);
      end else begin
         div_in = DV_W'(table_size);
      end
   end

   // byte sum as an adder tree
   assign key_all = {khi_ff, klo_ff};

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         lvl1[i] = SUM_MAX_W'(key_all[16*i +: 8]) + SUM_MAX_W'(key_all[16*i+8 +: 8]);
      end
      for (int i = 0; i < 4; i++) lvl2[i] = lvl1[2*i] + lvl1[2*i+1];
      for (int i = 0; i < 2; i++) lvl3[i] = lvl2[2*i] + lvl2[2*i+1];
      total = lvl3[0] + lvl3[1];
   end

   // restoring remainder step
   assign shifted = {rem_ff, sum_ff[SUM_W-1]};

   // sequencer
   always_comb begin
      state_in = state_ff;
      sum_in   = sum_ff;
      rem_in   = rem_ff;
      bit_in   = bit_ff;
      push     = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) state_in = F_SUM;
         end
         F_SUM: begin
            sum_in   = SUM_W'(total);
            rem_in   = '0;
            bit_in   = '0;
            state_in = F_DIV;
         end
         F_DIV: begin
            sum_in = sum_ff << 1;
            if (shifted >= {1'b0, div_ff}) begin
               rem_in = DV_W'(shifted - {1'b0, div_ff});
            end else begin
               rem_in = DV_W'(shifted);
            end
            bit_in = bit_ff + 1'b1;
            if (bit_ff == BC_W'(SUM_W - 1)) state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!queue_full) begin
               push     = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      push_data.op       = op_ff;
      push_data.key_low  = klo_ff;
      push_data.key_high = khi_ff;
      push_data.value    = val_ff;
      push_data.bucket   = BUCKET_MAX_W'(rem_ff);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_opcode;
         klo_ff <= klo_in;
         khi_ff <= khi_in;
         val_ff <= req_new_value;
         div_ff <= div_in;
      end
      sum_ff <= sum_in;
      rem_ff <= rem_in;
      bit_ff <= bit_in;
   end

endmodule

// ===== rtl/chte_queue.sv =====
// chte_queue: two-entry queue of classified transactions between front and back
// depends on chte_pkg for the transaction type
module chte_queue import chte_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_data,
   output logic     full,
   input  logic     pop,
   output logic     pop_valid,
   output work_type pop_data
);

   work_type   slot_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == 2'd2);
   assign pop_valid = (cnt_ff != 2'd0);
   assign pop_data  = slot_ff[rd_ff];

   // pointer and fill update
   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ pop;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_data;
   end

endmodule

// ===== rtl/chte_back.sv =====
// chte_back: walks bucket chains in the node pool and carries out search,
// insert and delete; depends on chte_pkg
module chte_back import chte_pkg::*; #(
   parameter int BUCKETS      = 64,
   parameter int POOL_ENTRIES = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  work_type                q_data,
   output logic                    q_pop,
   output back_status_type         status,
   output logic                    rsp_strobe,
   output logic                    rsp_hit,
   output logic signed [VAL_W-1:0] rsp_found_value,
   output logic                    rsp_full_res,
   output logic [ENTRY_W-1:0]      rsp_entry_count
);

   localparam int BI_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int NI_W  = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
   localparam int CNT_W = $clog2(POOL_ENTRIES + 1);

   typedef struct packed {
      logic            valid;
      logic [NI_W-1:0] idx;
   } head_type;

   typedef struct packed {
      logic [KEY_W-1:0]        key_low;
      logic [KEY_W-1:0]        key_high;
      logic signed [VAL_W-1:0] value;
      logic                    nxt_valid;
      logic [NI_W-1:0]         nxt;
   } node_type;

   // memories
   head_type        head_mem  [BUCKETS];
   node_type        node_mem  [POOL_ENTRIES];
   logic [NI_W-1:0] stack_mem [POOL_ENTRIES];

   head_type        head_rd_ff, head_wdata;
   node_type        node_rd_ff, node_wdata;
   logic [NI_W-1:0] stk_rd_ff, stk_wdata;
   logic            head_re, head_we, node_re, node_we, stk_re, stk_we;
   logic [BI_W-1:0] head_raddr, head_waddr;
   logic [NI_W-1:0] node_raddr, node_waddr, stk_raddr, stk_waddr;

   back_state_type          state_ff, state_in;
   work_type                item_ff, item_in;
   logic [NI_W-1:0]         cur_ff, cur_in, prev_ff, prev_in, new_ff, new_in;
   node_type                prev_node_ff, prev_node_in;
   logic                    have_prev_ff, have_prev_in, hit_ff, hit_in;
   logic [BI_W-1:0]         clr_ff, clr_in;
   logic [CNT_W-1:0]        fresh_ff, fresh_in, depth_ff, depth_in, count_ff, count_in;
   logic [CNT_W-1:0]        dep_m1;
   logic                    rsp_valid_ff, rsp_valid_in, hit_o_ff, hit_o_in;
   logic                    full_o_ff, full_o_in;
   logic signed [VAL_W-1:0] val_o_ff, val_o_in;
   logic [CNT_W-1:0]        cnt_o_ff, cnt_o_in;
   logic                    key_match, pool_full;
   logic [BI_W-1:0]         bucket;

   assign bucket    = item_ff.bucket[BI_W-1:0];
   assign dep_m1    = depth_ff - 1'b1;
   assign key_match = (node_rd_ff.key_low == item_ff.key_low) &&
                      (node_rd_ff.key_high == item_ff.key_high);
   assign pool_full = (fresh_ff == CNT_W'(POOL_ENTRIES)) && (depth_ff == '0);

   assign status.clearing = (state_ff == B_CLEAR);
   assign status.empty    = (count_ff == '0);

   assign rsp_strobe      = rsp_valid_ff;
   assign rsp_hit         = hit_o_ff;
   assign rsp_found_value = val_o_ff;
   assign rsp_full_res    = full_o_ff;
   assign rsp_entry_count = ENTRY_W'(cnt_o_ff);

   // sequencer: chain walk, decision and link updates
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      prev_node_in = prev_node_ff;
      have_prev_in = have_prev_ff;
      hit_in       = hit_ff;
      new_in       = new_ff;
      clr_in       = clr_ff;
      fresh_in     = fresh_ff;
      depth_in     = depth_ff;
      count_in     = count_ff;
      q_pop        = 1'b0;
      head_re      = 1'b0;
      head_raddr   = bucket;
      head_we      = 1'b0;
      head_waddr   = bucket;
      head_wdata   = '0;
      node_re      = 1'b0;
      node_raddr   = node_rd_ff.nxt;
      node_we      = 1'b0;
      node_waddr   = cur_ff;
      node_wdata   = node_rd_ff;
      stk_re       = 1'b0;
      stk_raddr    = dep_m1[NI_W-1:0];
      stk_we       = 1'b0;
      stk_waddr    = depth_ff[NI_W-1:0];
      stk_wdata    = cur_ff;
      rsp_valid_in = 1'b0;
      hit_o_in     = hit_ff;
      val_o_in     = '0;
      full_o_in    = 1'b0;
      cnt_o_in     = count_ff;
      unique case (state_ff)
         B_CLEAR: begin
            head_we    = 1'b1;
            head_waddr = clr_ff;
            head_wdata = '0;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == BI_W'(BUCKETS - 1)) state_in = B_IDLE;
         end
         B_IDLE: begin
            if (q_valid) begin
               q_pop        = 1'b1;
               item_in      = q_data;
               head_re      = 1'b1;
               head_raddr   = q_data.bucket[BI_W-1:0];
               have_prev_in = 1'b0;
               hit_in       = 1'b0;
               state_in     = B_HEAD;
            end
         end
         B_HEAD: begin
            if (head_rd_ff.valid) begin
               node_re    = 1'b1;
               node_raddr = head_rd_ff.idx;
               cur_in     = head_rd_ff.idx;
               state_in   = B_NODE;
            end else begin
               state_in = B_DECIDE;
            end
         end
         B_NODE: begin
            if (key_match) begin
               hit_in   = 1'b1;
               state_in = B_DECIDE;
            end else begin
               prev_in      = cur_ff;
               prev_node_in = node_rd_ff;
               have_prev_in = 1'b1;
               if (node_rd_ff.nxt_valid) begin
                  node_re    = 1'b1;
                  node_raddr = node_rd_ff.nxt;
                  cur_in     = node_rd_ff.nxt;
               end else begin
                  state_in = B_DECIDE;
               end
            end
         end
         B_DECIDE: begin
            priority if (item_ff.op == OP_INSERT && hit_ff) begin
               // update value in place
               node_we          = 1'b1;
               node_waddr       = cur_ff;
               node_wdata       = node_rd_ff;
               node_wdata.value = item_ff.value;
               rsp_valid_in     = 1'b1;
               state_in         = B_IDLE;
            end else if (item_ff.op == OP_INSERT && pool_full) begin
               full_o_in    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = B_IDLE;
            end else if (item_ff.op == OP_INSERT &&
                         fresh_ff < CNT_W'(POOL_ENTRIES)) begin
               // node never used so far
               new_in   = fresh_ff[NI_W-1:0];
               fresh_in = fresh_ff + 1'b1;
               state_in = B_LINK;
            end else if (item_ff.op == OP_INSERT) begin
               // reuse a freed node
               stk_re   = 1'b1;
               depth_in = dep_m1;
               state_in = B_POP;
            end else if (item_ff.op == OP_DELETE && hit_ff) begin
               if (have_prev_ff) begin
                  node_we              = 1'b1;
                  node_waddr           = prev_ff;
                  node_wdata           = prev_node_ff;
                  node_wdata.nxt_valid = node_rd_ff.nxt_valid;
                  node_wdata.nxt       = node_rd_ff.nxt;
               end else begin
                  head_we          = 1'b1;
                  head_wdata.valid = node_rd_ff.nxt_valid;
                  head_wdata.idx   = node_rd_ff.nxt;
               end
               stk_we       = 1'b1;
               depth_in     = depth_ff + 1'b1;
               count_in     = count_ff - 1'b1;
               cnt_o_in     = count_ff - 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = B_IDLE;
            end else begin
               // search, or delete of an absent key
               if (item_ff.op != OP_DELETE && hit_ff) val_o_in = node_rd_ff.value;
               rsp_valid_in = 1'b1;
               state_in     = B_IDLE;
            end
         end
         B_POP: begin
            new_in   = stk_rd_ff;
            state_in = B_LINK;
         end
         B_LINK: begin
            node_we              = 1'b1;
            node_waddr           = new_ff;
            node_wdata.key_low   = item_ff.key_low;
            node_wdata.key_high  = item_ff.key_high;
            node_wdata.value     = item_ff.value;
            node_wdata.nxt_valid = 1'b0;
            node_wdata.nxt       = '0;
            if (have_prev_ff) begin
               state_in = B_LINKP;
            end else begin
               head_we          = 1'b1;
               head_wdata.valid = 1'b1;
               head_wdata.idx   = new_ff;
               count_in         = count_ff + 1'b1;
               cnt_o_in         = count_ff + 1'b1;
               rsp_valid_in     = 1'b1;
               state_in         = B_IDLE;
            end
         end
         B_LINKP: begin
            node_we              = 1'b1;
            node_waddr           = prev_ff;
            node_wdata           = prev_node_ff;
            node_wdata.nxt_valid = 1'b1;
            node_wdata.nxt       = new_ff;
            count_in             = count_ff + 1'b1;
            cnt_o_in             = count_ff + 1'b1;
            rsp_valid_in         = 1'b1;
            state_in             = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         fresh_ff     <= '0;
         depth_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         fresh_ff     <= fresh_in;
         depth_ff     <= depth_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // walk context and result payload
   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      prev_node_ff <= prev_node_in;
      have_prev_ff <= have_prev_in;
      hit_ff       <= hit_in;
      new_ff       <= new_in;
      hit_o_ff     <= hit_o_in;
      val_o_ff     <= val_o_in;
      full_o_ff    <= full_o_in;
      cnt_o_ff     <= cnt_o_in;
   end

   // bucket head memory
   always_ff @(posedge clock) begin
      if (head_we) head_mem[head_waddr] <= head_wdata;
      if (head_re) head_rd_ff <= head_mem[head_raddr];
   end

   // node pool memory
   always_ff @(posedge clock) begin
      if (node_we) node_mem[node_waddr] <= node_wdata;
      if (node_re) node_rd_ff <= node_mem[node_raddr];
   end

   // freed node stack
   always_ff @(posedge clock) begin
      if (stk_we) stack_mem[stk_waddr] <= stk_wdata;
      if (stk_re) stk_rd_ff <= stack_mem[stk_raddr];
   end

   // between transactions, stored keys equal nodes handed out minus nodes waiting for reuse
   a_count_consistent: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_IDLE |-> count_ff == fresh_ff - depth_ff)
      else $error("stored count out of step with pool bookkeeping");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= fresh_ff)
      else $error("free stack deeper than nodes ever used");

   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_CLEAR |-> !q_pop)
      else $error("queue popped during head clearing");

   a_pop_on_full: assert property (@(posedge clock) disable iff (reset)
      stk_re |-> depth_ff != '0)
      else $error("pop from empty free stack");

endmodule

// ===== rtl/chained_hash_table_engine.sv =====
// chained_hash_table_engine: top level of the chained hash table engine
// depends on chte_pkg, chte_front, chte_queue and chte_back
//
//  channel  | ports                              | handshake
//  ---------+------------------------------------+----------------------------
//  request  | req_opcode/key_low/key_high/new_.. | start high while busy low
//  response | rsp_hit/found_value/full_res/ent.. | rsp_strobe, one cycle, no hold
//  csr      | csr_table_size                     | csr_valid and csr_ready
//
// After reset the bucket heads are cleared, one per cycle; busy stays high
// meanwhile. The front sums the key bytes, then reduces the sum with the
// one-bit-per-cycle remainder loop and pushes the item when the queue has room.
// The back reads the bucket head, walks the chain and links any new node.
// A two-entry queue lets the front take the next item while the back walks.
// Table size writes are dropped while keys are stored.
module chained_hash_table_engine import chte_pkg::*; #(
   parameter int BUCKETS      = 64,
   parameter int POOL_ENTRIES = 64,
   parameter int KEY_BYTES    = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [OP_W-1:0]         req_opcode,
   input  logic [KEY_W-1:0]        req_key_low,
   input  logic [KEY_W-1:0]        req_key_high,
   input  logic signed [VAL_W-1:0] req_new_value,
   output logic                    rsp_strobe,
   output logic                    rsp_hit,
   output logic signed [VAL_W-1:0] rsp_found_value,
   output logic                    rsp_full_res,
   output logic [ENTRY_W-1:0]      rsp_entry_count,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [TS_W-1:0]         csr_table_size
);

   logic [TS_W-1:0] table_size_ff, table_size_in;
   logic            front_busy, push, queue_full, q_pop, q_valid;
   work_type        push_data, q_data;
   back_status_type status;

   assign busy      = front_busy || status.clearing;
   assign csr_ready = 1'b1;

   // table size register, written only while empty
   always_comb begin
      table_size_in = table_size_ff;
      if (csr_valid && csr_ready && status.empty) table_size_in = csr_table_size;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= TS_RESET;
      end else begin
         table_size_ff <= table_size_in;
      end
   end

   chte_front #(
      .BUCKETS   (BUCKETS),
      .KEY_BYTES (KEY_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .hold          (status.clearing),
      .front_busy    (front_busy),
      .req_opcode    (req_opcode),
      .req_key_low   (req_key_low),
      .req_key_high  (req_key_high),
      .req_new_value (req_new_value),
      .table_size    (table_size_ff),
      .push          (push),
      .push_data     (push_data),
      .queue_full    (queue_full)
   );

   chte_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_data)
   );

   chte_back #(
      .BUCKETS      (BUCKETS),
      .POOL_ENTRIES (POOL_ENTRIES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_data          (q_data),
      .q_pop           (q_pop),
      .status          (status),
      .rsp_strobe      (rsp_strobe),
      .rsp_hit         (rsp_hit),
      .rsp_found_value (rsp_found_value),
      .rsp_full_res    (rsp_full_res),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

// ===== tb/chte_checker.sv =====
// chte_checker: watches the request, response and csr channels of the hash table engine,
// keeps its own table to predict each response and compares; depends on chte_pkg
module chte_checker import chte_pkg::*; #(
   parameter int BUCKETS      = 64,
   parameter int POOL_ENTRIES = 64,
   parameter int KEY_BYTES    = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    busy,
   input  logic [OP_W-1:0]         req_opcode,
   input  logic [KEY_W-1:0]        req_key_low,
   input  logic [KEY_W-1:0]        req_key_high,
   input  logic signed [VAL_W-1:0] req_new_value,
   input  logic                    rsp_strobe,
   input  logic                    rsp_hit,
   input  logic signed [VAL_W-1:0] rsp_found_value,
   input  logic                    rsp_full_res,
   input  logic [ENTRY_W-1:0]      rsp_entry_count,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [TS_W-1:0]         csr_table_size,
   output int                      fail_count,
   output int                      pending_count,
   output int                      response_count,
   output int                      hit_count,
   output int                      full_count
);

   typedef struct packed {
      logic                    hit;
      logic signed [VAL_W-1:0] found_value;
      logic                    full_res;
      logic [ENTRY_W-1:0]      entry_count;
   } answer_type;

   answer_type answer_q[$];

   // shadow table
   logic [TS_W-1:0]         size_reg;
   logic                    head_ok[BUCKETS];
   int                      head_idx[BUCKETS];
   logic [KEY_W-1:0]        slot_lo[POOL_ENTRIES];
   logic [KEY_W-1:0]        slot_hi[POOL_ENTRIES];
   logic signed [VAL_W-1:0] slot_val[POOL_ENTRIES];
   logic                    link_ok[POOL_ENTRIES];
   int                      link_idx[POOL_ENTRIES];
   logic                    slot_free[POOL_ENTRIES];
   int                      key_total;

   // apply one request to the shadow table and return the response it causes
   function automatic answer_type apply_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] lo,
                                                logic [KEY_W-1:0] hi, logic signed [VAL_W-1:0] v);
      answer_type a;
      logic [KEY_W-1:0] clo, chi;
      logic [7:0] b8;
      int sum, modulus, bkt, cur, prev, steps, n;
      logic have_cur, have_prev, found;
      clo = '0; chi = '0; sum = 0;
      for (int i = 0; i < KEY_BYTES && i < 16; i++) begin
         b8 = (i < 8) ? lo[8*i +: 8] : hi[8*(i-8) +: 8];
         if (b8 == 8'd0) break;
         sum += b8;
         if (i < 8) clo[8*i +: 8] = b8;
         else chi[8*(i-8) +: 8] = b8;
      end
      modulus = (size_reg == 0) ? 1 : ((size_reg > BUCKETS) ? BUCKETS : size_reg);
      bkt = sum % modulus;
      have_cur = head_ok[bkt]; cur = head_idx[bkt];
      have_prev = 0; prev = 0; steps = 0; found = 0;
      while (have_cur && steps < POOL_ENTRIES) begin
         if (slot_lo[cur] == clo && slot_hi[cur] == chi) begin
            found = 1;
            break;
         end
         have_prev = 1; prev = cur;
         have_cur = link_ok[cur]; cur = link_idx[cur];
         steps++;
      end
      a = '0;
      a.hit = found;
      if (op == OP_INSERT) begin
         if (found) slot_val[cur] = v;
         else begin
            n = -1;
            for (int i = 0; i < POOL_ENTRIES; i++)
               if (slot_free[i]) begin
                  n = i;
                  break;
               end
            if (n < 0) a.full_res = 1;
            else begin
               slot_free[n] = 0; slot_lo[n] = clo; slot_hi[n] = chi; slot_val[n] = v;
               link_ok[n] = 0; link_idx[n] = 0;
               if (have_prev) begin
                  link_ok[prev] = 1; link_idx[prev] = n;
               end else begin
                  head_ok[bkt] = 1; head_idx[bkt] = n;
               end
               key_total++;
            end
         end
      end else if (op == OP_DELETE) begin
         if (found) begin
            if (have_prev) begin
               link_ok[prev] = link_ok[cur]; link_idx[prev] = link_idx[cur];
            end else begin
               head_ok[bkt] = link_ok[cur]; head_idx[bkt] = link_idx[cur];
            end
            slot_free[cur] = 1; link_ok[cur] = 0;
            if (key_total > 0) key_total--;
         end
      end else if (found) a.found_value = slot_val[cur];
      a.entry_count = key_total[ENTRY_W-1:0];
      return a;
   endfunction

   // track transactions and compare responses
   always @(posedge clock) begin
      answer_type got, want;
      if (reset) begin
         size_reg = TS_RESET;
         for (int i = 0; i < BUCKETS; i++) begin
            head_ok[i] = 0; head_idx[i] = 0;
         end
         for (int i = 0; i < POOL_ENTRIES; i++) begin
            slot_free[i] = 1; link_ok[i] = 0; link_idx[i] = 0;
            slot_lo[i] = '0; slot_hi[i] = '0; slot_val[i] = '0;
         end
         key_total = 0;
         answer_q.delete();
         fail_count = 0; response_count = 0; hit_count = 0; full_count = 0;
      end else begin
         if (rsp_strobe) begin
            got = '{rsp_hit, rsp_found_value, rsp_full_res, rsp_entry_count};
            response_count++;
            if (answer_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected response %p", got);
            end else begin
               want = answer_q.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10) $display("response mismatch: expected %p, got %p",
                                                 want, got);
               end
               if (want.hit) hit_count++;
               if (want.full_res) full_count++;
            end
         end
         if (csr_valid && csr_ready && key_total == 0) size_reg = csr_table_size;
         if (start && !busy)
            answer_q.push_back(apply_request(req_opcode, req_key_low, req_key_high,
                                             req_new_value));
      end
      pending_count = answer_q.size();
   end

endmodule

// ===== tb/tb_chained_hash_table_engine.sv =====
// tb_chained_hash_table_engine: stimulus and verdict for the hash table engine
// depends on chte_pkg, chained_hash_table_engine and chte_checker
module tb_chained_hash_table_engine;
   import chte_pkg::*;

   localparam int LIMIT = 20000;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd0;
   localparam logic [OP_W-1:0] OP_SPARE  = 2'd3;

   logic                    clock = 0;
   logic                    reset = 1;
   logic                    start = 0;
   logic                    busy;
   logic [OP_W-1:0]         req_opcode = '0;
   logic [KEY_W-1:0]        req_key_low = '0;
   logic [KEY_W-1:0]        req_key_high = '0;
   logic signed [VAL_W-1:0] req_new_value = '0;
   logic                    rsp_strobe, rsp_hit, rsp_full_res;
   logic signed [VAL_W-1:0] rsp_found_value;
   logic [ENTRY_W-1:0]      rsp_entry_count;
   logic                    csr_valid = 0;
   logic                    csr_ready;
   logic [TS_W-1:0]         csr_table_size = '0;
   int fail_count, pending_count, response_count, hit_count, full_count;
   int idle_cycles = 0;
   int live_keys = 0;
   logic [KEY_W-1:0] key_pool_lo[16];
   logic [KEY_W-1:0] key_pool_hi[16];

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   chained_hash_table_engine u_dut (.*);

   chte_checker u_checker (.*);

   // watchdog over cycles with no accepted transaction
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= LIMIT) begin
         $display("watchdog expired");
         $display("end of test: mismatches");
         $finish;
      end
   end

   // send one request transaction after a random gap; start stays high
   // when the next transaction follows with no gap
   task automatic send_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] lo, logic [KEY_W-1:0] hi,
                               logic signed [VAL_W-1:0] v, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1; req_opcode <= op; req_key_low <= lo; req_key_high <= hi; req_new_value <= v;
      do @(posedge clock); while (busy);
   endtask

   // wait until the table is idle, then write the table size
   task automatic write_size(logic [TS_W-1:0] ts);
      start <= 0;
      wait_drain();
      csr_valid <= 1; csr_table_size <= ts;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
   endtask

   task automatic wait_drain();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // delete every pool key and the fill keys 4b01 to 4b46 (hex)
   task automatic empty_table();
      for (int i = 0; i < 16; i++) send_request(OP_DELETE, key_pool_lo[i], key_pool_hi[i], 0);
      for (int i = 0; i < 70; i++)
         send_request(OP_DELETE, 64'(i + 1) | 64'h4b00, 0, 0, 1);
   endtask

   function automatic logic [KEY_W-1:0] short_key();
      logic [KEY_W-1:0] k;
      k = '0;
      for (int i = 0; i < 3; i++) k[8*i +: 8] = 8'($urandom_range(1, 4));
      return k;
   endfunction

   initial begin
      logic [OP_W-1:0] op;
      int sel;
      logic [TS_W-1:0] sizes[6] = '{7'd1, 7'd0, 7'd127, 7'd64, 7'd7, 7'd3};
      repeat (5) @(posedge clock);
      reset <= 0;
      for (int i = 0; i < 16; i++) begin
         key_pool_lo[i] = {$urandom, $urandom};
         key_pool_hi[i] = (i < 8) ? 64'd0 : {$urandom, $urandom};
      end
      key_pool_lo[0] = 64'hffff_ffff_ffff_ffff; key_pool_hi[0] = 64'hffff_ffff_ffff_ffff;
      key_pool_lo[1] = 64'd0;                   key_pool_hi[1] = 64'h1234;
      key_pool_lo[2] = 64'h0000_00ff_0000_0041;

      // directed: empty key, padding ignored, extremes, every opcode
      send_request(OP_SEARCH, 64'd0, 64'd0, 0);
      send_request(OP_INSERT, 64'd0, 64'hdead, 32'sh7fffffff);
      send_request(OP_SPARE, 64'd0, 64'd0, 0);
      send_request(OP_INSERT, key_pool_lo[0], key_pool_hi[0], 32'sh80000000);
      send_request(OP_SEARCH, key_pool_lo[0], key_pool_hi[0], 0);
      send_request(OP_INSERT, key_pool_lo[2], 64'd0, -1);
      send_request(OP_SEARCH, 64'h41, 64'd0, 0);
      send_request(OP_INSERT, key_pool_lo[0], key_pool_hi[0], 5);
      send_request(OP_SPARE, key_pool_lo[0], key_pool_hi[0], 0);
      send_request(OP_DELETE, 64'h99, 64'd0, 0);
      write_size(7'd5);
      send_request(OP_DELETE, 64'h41, 64'd0, 0);
      send_request(OP_DELETE, 64'd0, 64'd0, 0);
      send_request(OP_DELETE, key_pool_lo[0], key_pool_hi[0], 0);
      send_request(OP_SEARCH, key_pool_lo[0], key_pool_hi[0], 0);

      // fill the pool past capacity for the full flag
      write_size(7'd2);
      for (int i = 0; i < 66; i++)
         send_request(OP_INSERT, 64'(i + 1) | 64'h4b00, 0, $urandom, 1);
      send_request(OP_SEARCH, 64'h4b05, 0, 0);
      empty_table();

      // random phases under several table sizes
      foreach (sizes[p]) begin
         write_size(sizes[p]);
         for (int n = 0; n < 170; n++) begin
            sel = $urandom_range(0, 9);
            op = (sel < 4) ? OP_INSERT : (sel < 7) ? OP_SEARCH : (sel < 9) ? OP_DELETE : OP_SPARE;
            case ($urandom_range(0, 3))
               0: begin
                  send_request(op, short_key(), 0, $urandom);
               end
               1: begin
                  send_request(op, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
               end
               default: begin
                  sel = $urandom_range(0, 15);
                  send_request(op, key_pool_lo[sel], key_pool_hi[sel], $urandom);
               end
            endcase
         end
         // short keys only cover a small space, so clear them out too
         for (int a = 1; a <= 4; a++)
            for (int b = 1; b <= 4; b++)
               for (int c = 1; c <= 4; c++)
                  send_request(OP_DELETE, {40'd0, 8'(c), 8'(b), 8'(a)}, 0, 0, 1);
         empty_table();
         // random long keys are unlikely to repeat and are not deleted here, so the
         // table may not be empty; a size write takes effect only when it is empty
      end

      start <= 0;
      wait_drain();
      $display("covered %0d responses, %0d hits, %0d full inserts", response_count, hit_count,
               full_count);
      $display("table sizes 1, 0, 127, 64, 7, 3 and 5, 2 were written");
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== chained_hash_table_engine.f =====
rtl/chte_pkg.sv
rtl/chte_front.sv
rtl/chte_queue.sv
rtl/chte_back.sv
rtl/chained_hash_table_engine.sv
tb/chte_checker.sv
tb/tb_chained_hash_table_engine.sv
